FILE: rtl/core/assert_macros.svh
// assertion macros shared by the date adder rtl
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// plain property, checked on every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/gda_pkg.sv
// types, constants and calendar helpers for the gregorian date adder
// no dependencies; used by gda_step, gda_core and the top level
`default_nettype none

package gda_pkg;

    // field widths
    localparam int OP_W            = 3;
    localparam int DAY_W           = 5;
    localparam int MONTH_W         = 4;
    localparam int YEAR_IN_W       = 14;
    localparam int YEAR_W          = 16;
    localparam int MOD400_W        = 9;
    localparam int MOD100_W        = 7;
    localparam int AMOUNT_BITS_DEF = 12;

    // calendar constants
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0] DAY_FIRST    = 5'd1;
    localparam logic [DAY_W-1:0] LEN_FEB      = 5'd28;
    localparam logic [DAY_W-1:0] LEN_FEB_LEAP = 5'd29;
    localparam logic [DAY_W-1:0] LEN_SHORT    = 5'd30;
    localparam logic [DAY_W-1:0] LEN_LONG     = 5'd31;

    localparam logic [MOD400_W-1:0] CYCLE_LAST   = 9'd399;
    localparam logic [MOD100_W-1:0] CENTURY_LAST = 7'd99;
    localparam logic [YEAR_IN_W-1:0] CYCLE_YEARS   = 14'd400;
    localparam logic [YEAR_IN_W-1:0] CENTURY_YEARS = 14'd100;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_DAYS    = 3'd0,
        OP_WEEKS   = 3'd1,
        OP_MONTHS  = 3'd2,
        OP_YEARS   = 3'd3,
        OP_DECADES = 3'd4
    } gda_op_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED400,
        ST_RED100,
        ST_RUN,
        ST_DONE
    } gda_state_t;

    // working date with year position inside the 400 and 100 year cycles
    typedef struct packed {
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        logic [MOD400_W-1:0] mod400;
        logic [MOD100_W-1:0] mod100;
    } gda_date_t;

    // core status toward the top level
    typedef struct packed {
        logic                busy;
        logic                running;
        logic                done;
        logic [MOD400_W-1:0] mod400;
        logic [MOD100_W-1:0] mod100;
    } gda_status_t;

    function automatic logic is_leap(input logic [1:0] year_low,
                                     input logic [MOD100_W-1:0] mod100,
                                     input logic [MOD400_W-1:0] mod400);
        return ((year_low == 2'b00) && (mod100 != '0)) || (mod400 == '0);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            MONTH_FEB: len = leap ? LEN_FEB_LEAP : LEN_FEB;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
            default: len = LEN_LONG;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gregorian_date_adder_top.sv
// gregorian date adder top, one day or month step a cycle; uses gda_pkg, gda_core, gda_step
// add days, weeks and months first reduce the year by 400 year and 100 year subtractions, then
// take one day step per day (seven per week) or one month step per month
// add years, add decades and unused op codes go straight to done; a stalled output holds done
// one request at a time: the next transfer is taken once the result is registered
// async active-low reset clears control state only; assertions from assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module gregorian_date_adder_top #(
    parameter int AMOUNT_BITS = gda_pkg::AMOUNT_BITS_DEF
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      s_tvalid,
    output logic                     s_tready,
    // op, amount, day_in, month_in, year_in from bit 0 up, zero padded
    input  wire [((AMOUNT_BITS + 26 + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire                      m_tready,
    // day_out, month_out, year_out from bit 0 up, zero padded
    output logic [31:0]              m_tdata
);

    localparam int AMT_LO   = gda_pkg::OP_W;
    localparam int DAY_LO   = AMT_LO + AMOUNT_BITS;
    localparam int MONTH_LO = DAY_LO + gda_pkg::DAY_W;
    localparam int YEAR_LO  = MONTH_LO + gda_pkg::MONTH_W;
    localparam int OUT_USED = gda_pkg::DAY_W + gda_pkg::MONTH_W + gda_pkg::YEAR_W;

    gda_pkg::gda_status_t status;
    gda_pkg::gda_date_t   result;
    logic                 start;
    logic                 out_free;
    logic                 out_valid_reg;
    logic [31:0]          out_data_reg;
    logic                 cycle_pos_ok;

    assign start    = s_tvalid && s_tready;
    assign s_tready = !status.busy;
    assign out_free = !out_valid_reg || m_tready;

    // sequencer with the shared step unit
    gda_core #(
        .AMOUNT_BITS (AMOUNT_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .op       (s_tdata[gda_pkg::OP_W-1:0]),
        .amount   (s_tdata[DAY_LO-1:AMT_LO]),
        .day_in   (s_tdata[MONTH_LO-1:DAY_LO]),
        .month_in (s_tdata[YEAR_LO-1:MONTH_LO]),
        .year_in  (s_tdata[YEAR_LO+gda_pkg::YEAR_IN_W-1:YEAR_LO]),
        .out_free (out_free),
        .status   (status),
        .result   (result)
    );

    // output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (status.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (status.done)
        begin
            out_data_reg <= {{(32 - OUT_USED){1'b0}}, result.year, result.month, result.day};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // cycle positions stay inside their cycles
    assign cycle_pos_ok = (status.mod400 < 9'd400) && (status.mod100 < 7'd100);

    // checks
    `ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, start, !s_tready)
    `ASSERT_IMPLIES(a_done_slot_free, clk, rst_n, status.done, (!m_tvalid || m_tready))
    `ASSERT_IMPLIES(a_cycle_pos_range, clk, rst_n, status.running, cycle_pos_ok)

endmodule

`default_nettype wire

FILE: rtl/core/gda_step.sv
// shared date step unit: advances a date by one day or by one month
// depends on gda_pkg
`default_nettype none

module gda_step (
    input  wire gda_pkg::gda_date_t cur,
    input  wire                     month_mode,
    output gda_pkg::gda_date_t      nxt
);

    gda_pkg::gda_date_t adv;
    logic               rollover;
    logic               leap_cur;
    logic               leap_adv;
    logic [gda_pkg::DAY_W-1:0] len_cur;
    logic [gda_pkg::DAY_W-1:0] len_adv;

    // month advance, with year and cycle positions on rollover
    always_comb
    begin
        adv      = cur;
        rollover = (cur.month >= gda_pkg::MONTH_DEC);
        if (rollover)
        begin
            adv.month  = gda_pkg::MONTH_JAN;
            adv.year   = cur.year + 16'd1;
            adv.mod400 = (cur.mod400 == gda_pkg::CYCLE_LAST) ? '0 : cur.mod400 + 9'd1;
            adv.mod100 = (cur.mod100 == gda_pkg::CENTURY_LAST) ? '0 : cur.mod100 + 7'd1;
        end
        else
        begin
            adv.month = cur.month + 4'd1;
        end
    end

    // month lengths before and after the advance
    assign leap_cur = gda_pkg::is_leap(cur.year[1:0], cur.mod100, cur.mod400);
    assign leap_adv = gda_pkg::is_leap(adv.year[1:0], adv.mod100, adv.mod400);
    assign len_cur  = gda_pkg::month_len(cur.month, leap_cur);
    assign len_adv  = gda_pkg::month_len(adv.month, leap_adv);

    // day step or month step with clamp
    always_comb
    begin
        nxt = cur;
        if (month_mode)
        begin
            nxt     = adv;
            nxt.day = (cur.day > len_adv) ? len_adv : cur.day;
        end
        else if (cur.day >= len_cur)
        begin
            nxt     = adv;
            nxt.day = gda_pkg::DAY_FIRST;
        end
        else
        begin
            nxt.day = cur.day + 5'd1;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/gda_core.sv
// sequencer of the date adder: year cycle reduction, then repeated steps; years and decades are added directly
// depends on gda_pkg and gda_step
`default_nettype none

module gda_core #(
    parameter int AMOUNT_BITS = gda_pkg::AMOUNT_BITS_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    input  wire [gda_pkg::OP_W-1:0]          op,
    input  wire [AMOUNT_BITS-1:0]            amount,
    input  wire [gda_pkg::DAY_W-1:0]         day_in,
    input  wire [gda_pkg::MONTH_W-1:0]       month_in,
    input  wire [gda_pkg::YEAR_IN_W-1:0]     year_in,
    input  wire                              out_free,
    output gda_pkg::gda_status_t             status,
    output gda_pkg::gda_date_t               result
);

    localparam int CNT_W  = AMOUNT_BITS + 3;
    localparam int DEC_W  = AMOUNT_BITS + 4;
    localparam int WIDE_W = (DEC_W > gda_pkg::YEAR_W) ? DEC_W : gda_pkg::YEAR_W;

    gda_pkg::gda_state_t state_reg, state_next;
    gda_pkg::gda_date_t  date_reg, date_next;
    gda_pkg::gda_date_t  step_out;
    logic [gda_pkg::YEAR_IN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                mode_reg, mode_next;
    logic                done;

    logic [CNT_W-1:0]    weeks_days;
    logic [WIDE_W-1:0]   decade_years;

    // shared step unit
    gda_step u_step (
        .cur        (date_reg),
        .month_mode (mode_reg),
        .nxt        (step_out)
    );

    // amount times seven and times ten by shifts
    assign weeks_days   = {amount, 3'b000} - CNT_W'(amount);
    assign decade_years = WIDE_W'({amount, 3'b000}) + WIDE_W'({amount, 1'b0});

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gda_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        date_reg <= date_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        mode_reg <= mode_next;
    end

    // next state and datapath control
    always_comb
    begin
        state_next = state_reg;
        date_next  = date_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        mode_next  = mode_reg;
        done       = 1'b0;
        case (state_reg)
            gda_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    date_next.day    = day_in;
                    date_next.month  = month_in;
                    date_next.year   = gda_pkg::YEAR_W'(year_in);
                    date_next.mod400 = '0;
                    date_next.mod100 = '0;
                    rem_next         = year_in;
                    cnt_next         = CNT_W'(amount);
                    mode_next        = 1'b0;
                    case (gda_pkg::gda_op_t'(op))
                        gda_pkg::OP_DAYS:   state_next = gda_pkg::ST_RED400;
                        gda_pkg::OP_WEEKS:
                        begin
                            cnt_next   = weeks_days;
                            state_next = gda_pkg::ST_RED400;
                        end
                        gda_pkg::OP_MONTHS:
                        begin
                            mode_next  = 1'b1;
                            state_next = gda_pkg::ST_RED400;
                        end
                        gda_pkg::OP_YEARS:
                        begin
                            date_next.year = gda_pkg::YEAR_W'(WIDE_W'(year_in)
                                                              + WIDE_W'(amount));
                            state_next     = gda_pkg::ST_DONE;
                        end
                        gda_pkg::OP_DECADES:
                        begin
                            date_next.year = gda_pkg::YEAR_W'(WIDE_W'(year_in)
                                                              + decade_years);
                            state_next     = gda_pkg::ST_DONE;
                        end
                        default: state_next = gda_pkg::ST_DONE;
                    endcase
                end
            end
            gda_pkg::ST_RED400:
            begin
                if (rem_reg >= gda_pkg::CYCLE_YEARS)
                begin
                    rem_next = rem_reg - gda_pkg::CYCLE_YEARS;
                end
                else
                begin
                    date_next.mod400 = rem_reg[gda_pkg::MOD400_W-1:0];
                    state_next       = gda_pkg::ST_RED100;
                end
            end
            gda_pkg::ST_RED100:
            begin
                if (rem_reg >= gda_pkg::CENTURY_YEARS)
                begin
                    rem_next = rem_reg - gda_pkg::CENTURY_YEARS;
                end
                else
                begin
                    date_next.mod100 = rem_reg[gda_pkg::MOD100_W-1:0];
                    state_next       = gda_pkg::ST_RUN;
                end
            end
            gda_pkg::ST_RUN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = gda_pkg::ST_DONE;
                end
                else
                begin
                    date_next = step_out;
                    cnt_next  = cnt_reg - CNT_W'(1);
                end
            end
            gda_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = gda_pkg::ST_IDLE;
                end
            end
            default: state_next = gda_pkg::ST_IDLE;
        endcase
    end

    // status and result toward the top level
    assign status.busy    = (state_reg != gda_pkg::ST_IDLE);
    assign status.running = (state_reg == gda_pkg::ST_RUN);
    assign status.done    = done;
    assign status.mod400  = date_reg.mod400;
    assign status.mod100  = date_reg.mod100;
    assign result         = date_reg;

endmodule

`default_nettype wire

FILE: verif/date_shift_checker.sv
// checker for the gregorian date adder: watches both stream channels, predicts each shifted date
// and compares every output transfer field by field; depends on gda_pkg only
`default_nettype none

module date_shift_checker #(
    parameter int AMOUNT_BITS = gda_pkg::AMOUNT_BITS_DEF,
    parameter int REQ_W       = ((AMOUNT_BITS + 26 + 7) / 8) * 8
) (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             s_tvalid,
    input  wire             s_tready,
    // op, amount, day_in, month_in, year_in from bit 0 up, zero padded
    input  wire [REQ_W-1:0] s_tdata,
    input  wire             m_tvalid,
    input  wire             m_tready,
    // day_out, month_out, year_out from bit 0 up, zero padded
    input  wire [31:0]      m_tdata,
    output int              errors,
    output int              pending
);

    import gda_pkg::*;

    localparam int DAY_LSB   = OP_W + AMOUNT_BITS;
    localparam int MONTH_LSB = DAY_LSB + DAY_W;
    localparam int YEAR_LSB  = MONTH_LSB + MONTH_W;
    localparam int RES_USED  = DAY_W + MONTH_W + YEAR_W;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } cal_date_t;

    cal_date_t shifted_q[$];
    cal_date_t want;
    cal_date_t start;
    int        err_count = 0;
    int        open_count = 0;

    assign errors  = err_count;
    assign pending = open_count;

    // gregorian leap rule on the full 16-bit year
    function automatic bit is_leap_year(input logic [YEAR_W-1:0] y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // length of a month; months outside 1..12 are treated as long months
    function automatic logic [DAY_W-1:0] days_in_month(input logic [YEAR_W-1:0] y,
                                                       input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            MONTH_FEB: len = is_leap_year(y) ? LEN_FEB_LEAP : LEN_FEB;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
            default: len = LEN_LONG;
        endcase
        return len;
    endfunction

    // one day forward; a day at or past the month end rolls to day one
    function automatic cal_date_t next_day(input cal_date_t dt);
        cal_date_t r;
        r = dt;
        if (r.day >= days_in_month(r.year, r.month))
        begin
            r.day = DAY_FIRST;
            if (r.month >= MONTH_DEC)
            begin
                r.month = MONTH_JAN;
                r.year  = r.year + YEAR_W'(1);
            end
            else
            begin
                r.month = r.month + MONTH_W'(1);
            end
        end
        else
        begin
            r.day = r.day + DAY_W'(1);
        end
        return r;
    endfunction

    // one month forward, day clamped to the new month length
    function automatic cal_date_t next_month(input cal_date_t dt);
        cal_date_t        r;
        logic [DAY_W-1:0] len;
        r = dt;
        if (r.month >= MONTH_DEC)
        begin
            r.month = MONTH_JAN;
            r.year  = r.year + YEAR_W'(1);
        end
        else
        begin
            r.month = r.month + MONTH_W'(1);
        end
        len = days_in_month(r.year, r.month);
        if (r.day > len)
            r.day = len;
        return r;
    endfunction

    // date after applying op with the given amount; spare op codes leave it alone
    function automatic cal_date_t shifted_date(input logic [OP_W-1:0] op,
                                               input logic [AMOUNT_BITS-1:0] amt,
                                               input cal_date_t from);
        cal_date_t   r;
        int unsigned units;
        r     = from;
        units = 32'(amt);
        case (op)
            OP_DAYS:    for (int unsigned i = 0; i < units; i++) r = next_day(r);
            OP_WEEKS:   for (int unsigned i = 0; i < units * 7; i++) r = next_day(r);
            OP_MONTHS:  for (int unsigned i = 0; i < units; i++) r = next_month(r);
            OP_YEARS:   r.year = YEAR_W'(32'(r.year) + units);
            OP_DECADES: r.year = YEAR_W'(32'(r.year) + units * 10);
            default:    r = from;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned exp_val,
                                   input int unsigned got_val);
        $display("mismatch at %0t: %s expected %0d got %0d", $time, what, exp_val, got_val);
        err_count++;
    endtask

    // predict on every input transfer, check on every output transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                start.day   = s_tdata[DAY_LSB +: DAY_W];
                start.month = s_tdata[MONTH_LSB +: MONTH_W];
                start.year  = YEAR_W'(s_tdata[YEAR_LSB +: YEAR_IN_W]);
                shifted_q.push_back(shifted_date(s_tdata[OP_W-1:0],
                                                 s_tdata[OP_W +: AMOUNT_BITS], start));
            end
            if (m_tvalid && m_tready)
            begin
                if (shifted_q.size() == 0)
                begin
                    report_mismatch("result with nothing pending, tdata", 0, m_tdata);
                end
                else
                begin
                    want = shifted_q.pop_front();
                    if (m_tdata[0 +: DAY_W] !== want.day)
                        report_mismatch("day_out", 32'(want.day), 32'(m_tdata[0 +: DAY_W]));
                    if (m_tdata[DAY_W +: MONTH_W] !== want.month)
                        report_mismatch("month_out", 32'(want.month),
                                        32'(m_tdata[DAY_W +: MONTH_W]));
                    if (m_tdata[DAY_W + MONTH_W +: YEAR_W] !== want.year)
                        report_mismatch("year_out", 32'(want.year),
                                        32'(m_tdata[DAY_W + MONTH_W +: YEAR_W]));
                    if (m_tdata[31:RES_USED] !== '0)
                        report_mismatch("padding", 0, 32'(m_tdata[31:RES_USED]));
                end
            end
            open_count <= shifted_q.size();
        end
    end

endmodule

`default_nettype wire

FILE: verif/tb_gregorian_date_adder_top.sv
// testbench top for the gregorian date adder: clock, reset, directed and random date requests
// with idling on both channels; depends on gda_pkg, the rtl and date_shift_checker
`default_nettype none

module tb_gregorian_date_adder_top;

    import gda_pkg::*;

    localparam int AMT_W       = AMOUNT_BITS_DEF;
    localparam int REQ_W       = ((AMT_W + 26 + 7) / 8) * 8;
    localparam int PAD_W       = REQ_W - AMT_W - 26;
    localparam int RAND_ITEMS  = 517;   // per idling phase
    localparam int DRAIN_CYCLES = 40;

    localparam logic [OP_W-1:0]      OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0]      OP_SPARE_LAST  = 3'd7;
    localparam logic [AMT_W-1:0]     AMT_TOP        = {AMT_W{1'b1}};
    localparam logic [YEAR_IN_W-1:0] YEAR_TOP       = {YEAR_IN_W{1'b1}};
    localparam logic [MONTH_W-1:0]   MONTH_NONE     = 4'd0;
    localparam logic [MONTH_W-1:0]   MONTH_OVER     = 4'd13;
    localparam logic [MONTH_W-1:0]   MONTH_TOP      = 4'd15;
    localparam logic [DAY_W-1:0]     DAY_NONE       = 5'd0;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [REQ_W-1:0] s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [31:0]      m_tdata;
    int               errors;
    int               pending;
    int               src_idle_pct = 12;
    int               snk_idle_pct = 45;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    gregorian_date_adder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    date_shift_checker #(.AMOUNT_BITS(AMT_W)) u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    // receiver stalls at random
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= snk_idle_pct);

    // offer one request after random idle cycles and hold it until the transfer
    task automatic offer_request(input logic [OP_W-1:0] op, input logic [AMT_W-1:0] amt,
                                 input logic [DAY_W-1:0] day, input logic [MONTH_W-1:0] month,
                                 input logic [YEAR_IN_W-1:0] year);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, year, month, day, amt, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    initial
    begin
        logic [OP_W-1:0]      op;
        logic [AMT_W-1:0]     amt;
        logic [DAY_W-1:0]     day;
        logic [MONTH_W-1:0]   month;
        logic [YEAR_IN_W-1:0] year;
        int                   pick;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, every op, leap rules and out-of-range dates
        offer_request(OP_DAYS,    '0,      DAY_FIRST, MONTH_JAN, '0);
        offer_request(OP_DAYS,    AMT_W'(1), LEN_LONG, MONTH_DEC, 14'd9999);
        offer_request(OP_DAYS,    AMT_W'(1), LEN_FEB,  MONTH_FEB, 14'd2024);
        offer_request(OP_DAYS,    AMT_W'(1), LEN_FEB,  MONTH_FEB, 14'd1900);
        offer_request(OP_DAYS,    AMT_W'(1), LEN_FEB,  MONTH_FEB, 14'd2000);
        offer_request(OP_DAYS,    AMT_TOP, DAY_FIRST, MONTH_JAN, '0);
        offer_request(OP_WEEKS,   AMT_TOP, 5'd15,     MONTH_JUN, 14'd9999);
        offer_request(OP_WEEKS,   AMT_W'(1), 5'd25,    MONTH_DEC, 14'd2023);
        offer_request(OP_MONTHS,  AMT_W'(1), LEN_LONG, MONTH_JAN, 14'd2023);
        offer_request(OP_MONTHS,  AMT_W'(1), LEN_LONG, MONTH_JAN, 14'd2024);
        offer_request(OP_MONTHS,  AMT_TOP, LEN_LONG,  MONTH_DEC, YEAR_TOP);
        offer_request(OP_MONTHS,  AMT_W'(1), LEN_LONG, 4'd3,     14'd2021);
        offer_request(OP_YEARS,   AMT_W'(1), LEN_FEB_LEAP, MONTH_FEB, 14'd2024);
        offer_request(OP_YEARS,   AMT_TOP, 5'd7,      MONTH_NOV, YEAR_TOP);
        offer_request(OP_DECADES, AMT_TOP, 5'd3,      MONTH_SEP, YEAR_TOP);
        offer_request(OP_DECADES, '0,      5'd3,      MONTH_SEP, 14'd1234);
        offer_request(OP_SPARE_FIRST, AMT_TOP, 5'd9,  MONTH_APR, 14'd5555);
        offer_request(OP_SPARE_LAST,  AMT_W'(5), LEN_LONG, MONTH_DEC, YEAR_TOP);
        // month zero and months past december behave as long months; months past december end the year
        offer_request(OP_DAYS,    AMT_W'(2), LEN_LONG, MONTH_NONE, 14'd2000);
        offer_request(OP_DAYS,    AMT_W'(1), LEN_LONG, MONTH_OVER, 14'd2000);
        offer_request(OP_MONTHS,  AMT_W'(1), 5'd20,    MONTH_TOP,  14'd1999);
        // day zero steps to day one, but survives a month step
        offer_request(OP_DAYS,    AMT_W'(1), DAY_NONE, MONTH_FEB, 14'd2001);
        offer_request(OP_MONTHS,  AMT_W'(3), DAY_NONE, MONTH_JAN, 14'd2001);
        offer_request(OP_DAYS,    AMT_W'(1), LEN_LONG, MONTH_APR, 14'd2010);

        // random: mostly plausible dates, some raw field noise
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct = 12;
                    snk_idle_pct = 45;
                end
                1:
                begin
                    src_idle_pct = 45;
                    snk_idle_pct = 12;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < RAND_ITEMS; k++)
            begin
                if ($urandom_range(99) < 10)
                begin
                    op    = OP_W'($urandom_range(OP_DAYS, OP_SPARE_LAST));
                    day   = DAY_W'($urandom_range(0, 31));
                    month = MONTH_W'($urandom_range(0, 15));
                    year  = YEAR_IN_W'($urandom_range(0, YEAR_TOP));
                end
                else
                begin
                    op    = OP_W'($urandom_range(OP_DAYS, OP_DECADES));
                    month = MONTH_W'($urandom_range(MONTH_JAN, MONTH_DEC));
                    day   = ($urandom_range(3) == 0) ? DAY_W'($urandom_range(28, 31))
                                                     : DAY_W'($urandom_range(1, 28));
                    year  = ($urandom_range(4) == 0)
                          ? YEAR_IN_W'($urandom_range(0, 99) * 100 + $urandom_range(0, 4))
                          : YEAR_IN_W'($urandom_range(0, 9999));
                end
                // large amounts are slow for day and week steps, so keep them rare
                pick = $urandom_range(99);
                if (pick < 2)
                    amt = AMT_W'($urandom_range(0, AMT_TOP));
                else if (pick < 15)
                    amt = AMT_W'($urandom_range(0, 400));
                else
                    amt = AMT_W'($urandom_range(0, 40));
                offer_request(op, amt, day, month, year);
            end
        end
        s_tvalid <= 1'b0;

        // drain outstanding results, then watch for stray output transfers
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #250_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

FILE: gregorian_date_adder_top.f
+incdir+rtl/core
rtl/core/gda_pkg.sv
rtl/core/gda_step.sv
rtl/core/gda_core.sv
rtl/core/gregorian_date_adder_top.sv
verif/date_shift_checker.sv
verif/tb_gregorian_date_adder_top.sv
